// ----- rtl/otspwm_pkg.sv -----
// shared types, constants and the sine table generator of the three-phase sine pwm
// used by otspwm_sine_rom and open_loop_three_phase_sine_pwm; no dependencies
package otspwm_pkg;

  // sequencer states of the shared multiplier
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M_DT,
    ST_M_LO,
    ST_M_HI,
    ST_INC,
    ST_Q_EST,
    ST_Q_MUL,
    ST_Q_FIX,
    ST_MS,
    ST_D,
    ST_DM,
    ST_FIN
  } st_e;

  // signed sine sample out of the quarter-wave rom
  typedef struct packed {
    logic        neg;
    logic [15:0] mag;
  } sine_t;

  // register byte addresses
  localparam logic [2:0] REG_VOLTAGE = 3'd0;
  localparam logic [2:0] REG_REVERSE = 3'd4;

  localparam logic [12:0] VOLT_RESET = 13'd6000;
  localparam logic [12:0] V_MIN      = 13'd500;
  localparam logic [12:0] V_MAX      = 13'd8000;

  localparam logic signed [15:0] VEL_LIMIT = 16'sd20000;

  // round(11 * 2^56 / (2*pi*1e9))
  localparam logic [31:0] VEL_K = 32'd126151545;

  // modulation depth m = round(v * 65536 / 22700), capped at 0.45 in q16
  localparam logic [31:0] M_DIV       = 32'd22700;
  localparam logic [28:0] M_ROUND     = 29'd11350;
  localparam logic [14:0] M_CAP       = 15'd29491;
  localparam int          RECIP_SHIFT = 44;
  localparam logic [31:0] M_RECIP     = 32'((64'd1 << RECIP_SHIFT) / 64'd22700);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

  // q15 sine of entry idx of a quarter wave split into 2^tab_bits steps,
  // odd taylor series to the x^11 term in q30
  function automatic logic [15:0] sine_q15_f(input int unsigned idx,
                                             input int unsigned tab_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sn;
    x  = (64'(idx) * HALF_PI_Q30) >> tab_bits;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    sn = (x * t) >> 30;
    return 16'((sn + 64'd16384) >> 15);
  endfunction

endpackage

// ----- rtl/otspwm_sine_rom.sv -----
// quarter-wave sine rom with phase rounding and quadrant mirroring, registered read
// depends on otspwm_pkg for the table generator and the sample struct
module otspwm_sine_rom #(
  parameter int SINE_TABLE_BITS = 8,
  parameter int PHASE_BITS      = 32
) (
  input  logic                  clk_i,
  input  logic [PHASE_BITS-1:0] phase_i,
  output otspwm_pkg::sine_t     sine_o
);
  import otspwm_pkg::*;

  localparam int TAB_LEN = (1 << SINE_TABLE_BITS) + 1;
  localparam int SHIFT   = PHASE_BITS - SINE_TABLE_BITS - 2;
  localparam logic [PHASE_BITS-1:0] HALF_STEP = PHASE_BITS'(1) << (SHIFT - 1);

  logic [15:0]                  tab [TAB_LEN];
  logic [PHASE_BITS-1:0]        rnd;
  logic [SINE_TABLE_BITS+1:0]   idx;
  logic [1:0]                   quad;
  logic [SINE_TABLE_BITS:0]     off;
  logic [SINE_TABLE_BITS:0]     addr;
  sine_t                        sine_q;

  always_comb begin
    for (int i = 0; i < TAB_LEN; i++) begin
      tab[i] = sine_q15_f(i, SINE_TABLE_BITS);
    end
  end

  // round to the nearest of four times the table steps, then fold the quadrant
  always_comb begin
    rnd  = phase_i + HALF_STEP;
    idx  = rnd[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
    quad = idx[SINE_TABLE_BITS+1:SINE_TABLE_BITS];
    off  = {1'b0, idx[SINE_TABLE_BITS-1:0]};
    addr = quad[0] ? ((SINE_TABLE_BITS+1)'(TAB_LEN - 1) - off) : off;
  end

  always_ff @(posedge clk_i) begin
    sine_q.mag <= tab[addr];
    sine_q.neg <= quad[1];
  end

  assign sine_o = sine_q;

endmodule

// ----- rtl/open_loop_three_phase_sine_pwm.sv -----
// open-loop three-phase sine pwm: phase accumulator, modulation depth and duties
// built on one shared 32x32 multiplier; uses otspwm_pkg and otspwm_sine_rom
// a run word passes through the phase step, depth and duty states to the final state; a stop word goes straight there
// one word at a time: a new word is taken only in the idle state, once the last has left the final state
// (the shared multiplier forms three products for the phase step, two for the depth, two per phase for the duties)
// the output register lets the next word in while a result waits to be taken
// reset: config to 6000 mV forward, phase and tick history cleared, no result pending
module open_loop_three_phase_sine_pwm #(
  parameter int PWM_BITS        = 10,
  parameter int SINE_TABLE_BITS = 8,
  parameter int PHASE_BITS      = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // tick words in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // now_us [31:0], target_velocity_mrad [47:32]
  input  logic        s_axis_tuser,   // run
  // duty words out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // duty_a, duty_b, duty_c, electrical_phase from the lowest bits up, zero filled
  output logic [((3*PWM_BITS+16+7)/8)*8-1:0] m_axis_tdata
);
  import otspwm_pkg::*;

  localparam int OUT_W     = 3*PWM_BITS + 16;
  localparam int OUT_BUS_W = ((OUT_W + 7) / 8) * 8;
  localparam int INC_SHIFT = 56 - PHASE_BITS;
  localparam logic [55:0] INC_HALF = 56'd1 << (INC_SHIFT - 1);
  localparam logic [PHASE_BITS-1:0] THIRD =
    PHASE_BITS'(((64'd1 << PHASE_BITS) + 64'd1) / 64'd3);
  localparam logic [31:0] DUTY_MAX = 32'((64'd1 << PWM_BITS) - 64'd1);
  localparam logic [PWM_BITS-1:0] DUTY_MID = PWM_BITS'(DUTY_MAX >> 1);
  localparam logic [32:0] D_HALF = 33'd1 << 30;
  localparam logic [32:0] D_FULL = 33'd1 << 31;

  st_e state_q, state_d;

  logic [12:0]           volt_q;
  logic                  rev_q;
  logic                  tick_valid_q;
  logic [31:0]           last_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic [14:0]           mag_q;
  logic                  neg_q;
  logic [31:0]           dt_q;
  logic [14:0]           p1hi_q;
  logic [55:0]           acc_q;
  logic [PHASE_BITS-1:0] inc_q;
  logic [28:0]           num_q;
  logic [15:0]           q_q;
  logic [14:0]           m_q;
  logic [1:0]            ch_q;
  logic                  sneg_q;
  logic [31:0]           d_q;
  logic [PWM_BITS-1:0]   duty_a_q;
  logic [PWM_BITS-1:0]   duty_b_q;
  logic                  center_q;
  logic [63:0]           prod_q;
  logic                  out_valid_q;
  logic [OUT_BUS_W-1:0]  out_data_q;

  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic                  in_fire;
  logic                  out_free;
  logic                  cfg_wr;

  logic signed [15:0]    vel_in;
  logic signed [15:0]    vel_sat;
  logic [12:0]           volt_sat;
  logic [55:0]           inc_sum;
  logic [28:0]           rem;
  logic [15:0]           q_fix;
  logic [PWM_BITS-1:0]   duty_new;
  logic [32:0]           d_calc;
  logic [PHASE_BITS-1:0] rom_phase;
  sine_t                 sine;

  assign pready        = 1'b1;
  assign cfg_wr        = psel & penable & pwrite & pready;
  assign prdata        = paddr[2] ? {31'd0, rev_q} : {19'd0, volt_q};
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign duty_new      = prod_q[31 +: PWM_BITS];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_q <= VOLT_RESET;
      rev_q  <= 1'b0;
    end else if (cfg_wr) begin
      if ((paddr & REG_REVERSE) == REG_VOLTAGE) begin
        volt_q <= pwdata[12:0];
      end else begin
        rev_q <= pwdata[0];
      end
    end
  end

  // velocity limit and direction, voltage limit
  always_comb begin
    vel_in  = s_axis_tdata[47:32];
    vel_sat = vel_in;
    if (vel_in > VEL_LIMIT) begin
      vel_sat = VEL_LIMIT;
    end else if (vel_in < -VEL_LIMIT) begin
      vel_sat = -VEL_LIMIT;
    end
    if (rev_q) begin
      vel_sat = -vel_sat;
    end
    volt_sat = volt_q;
    if (volt_q < V_MIN) begin
      volt_sat = V_MIN;
    end else if (volt_q > V_MAX) begin
      volt_sat = V_MAX;
    end
  end

  // datapath helpers
  always_comb begin
    inc_sum = acc_q + {prod_q[23:0], 32'd0};
    rem     = num_q - prod_q[28:0];
    q_fix   = (32'(rem) >= M_DIV) ? (q_q + 16'd1) : q_q;
    if (sneg_q) begin
      d_calc = (33'(prod_q[31:0]) > D_HALF) ? 33'd0 : (D_HALF - 33'(prod_q[31:0]));
    end else begin
      d_calc = D_HALF + 33'(prod_q[31:0]);
      if (d_calc > D_FULL) begin
        d_calc = D_FULL;
      end
    end
    case (ch_q)
      2'd1:    rom_phase = phase_q - THIRD;
      2'd2:    rom_phase = phase_q + THIRD;
      default: rom_phase = phase_q;
    endcase
  end

  otspwm_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS),
    .PHASE_BITS     (PHASE_BITS)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .phase_i(rom_phase),
    .sine_o (sine)
  );

  // sequencer: next state and multiplier operands
  always_comb begin
    state_d = state_q;
    mul_a   = 32'd0;
    mul_b   = 32'd0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = s_axis_tuser ? ST_M_DT : ST_FIN;
        end
      end
      ST_M_DT: begin
        mul_a   = 32'(mag_q);
        mul_b   = dt_q;
        state_d = ST_M_LO;
      end
      ST_M_LO: begin
        mul_a   = prod_q[31:0];
        mul_b   = VEL_K;
        state_d = ST_M_HI;
      end
      ST_M_HI: begin
        mul_a   = 32'(p1hi_q);
        mul_b   = VEL_K;
        state_d = ST_INC;
      end
      ST_INC: begin
        mul_a   = 32'(num_q);
        mul_b   = M_RECIP;
        state_d = ST_Q_EST;
      end
      ST_Q_EST: begin
        state_d = ST_Q_MUL;
      end
      ST_Q_MUL: begin
        mul_a   = 32'(q_q);
        mul_b   = M_DIV;
        state_d = ST_Q_FIX;
      end
      ST_Q_FIX: begin
        state_d = ST_MS;
      end
      ST_MS: begin
        mul_a   = 32'(m_q);
        mul_b   = 32'(sine.mag);
        state_d = ST_D;
      end
      ST_D: begin
        state_d = ST_DM;
      end
      ST_DM: begin
        mul_a   = d_q;
        mul_b   = DUTY_MAX;
        state_d = (ch_q == 2'd3) ? ST_FIN : ST_MS;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_q <= 1'b0;
      last_q       <= 32'd0;
      phase_q      <= '0;
      ch_q         <= 2'd0;
      center_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        ch_q     <= 2'd0;
        center_q <= ~s_axis_tuser;
        if (s_axis_tuser) begin
          tick_valid_q <= 1'b1;
          last_q       <= s_axis_tdata[31:0];
        end else begin
          tick_valid_q <= 1'b0;
          last_q       <= 32'd0;
        end
      end
      if (state_q == ST_Q_EST) begin
        phase_q <= neg_q ? (phase_q - inc_q) : (phase_q + inc_q);
      end
      // rom address moves on to the next phase once the sample is taken
      if (state_q == ST_MS) begin
        ch_q <= ch_q + 2'd1;
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    // the last product holds duty_c until the result register frees up
    if (state_q != ST_FIN) begin
      prod_q <= 64'(mul_a) * 64'(mul_b);
    end
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mag_q    <= vel_sat[15] ? 15'(-vel_sat) : 15'(vel_sat);
          neg_q    <= vel_sat[15];
          dt_q     <= tick_valid_q ? (s_axis_tdata[31:0] - last_q) : 32'd0;
          num_q    <= {volt_sat, 16'd0} + M_ROUND;
          duty_a_q <= DUTY_MID;
          duty_b_q <= DUTY_MID;
        end
      end
      ST_M_LO: begin
        p1hi_q <= prod_q[46:32];
      end
      ST_M_HI: begin
        acc_q <= prod_q[55:0] + INC_HALF;
      end
      ST_INC: begin
        inc_q <= inc_sum[55 -: PHASE_BITS];
      end
      ST_Q_EST: begin
        q_q <= prod_q[RECIP_SHIFT +: 16];
      end
      ST_Q_FIX: begin
        m_q <= (q_fix > 16'(M_CAP)) ? M_CAP : q_fix[14:0];
      end
      ST_MS: begin
        sneg_q <= sine.neg;
        if (ch_q == 2'd1) begin
          duty_a_q <= duty_new;
        end
        if (ch_q == 2'd2) begin
          duty_b_q <= duty_new;
        end
      end
      ST_D: begin
        d_q <= d_calc[31:0];
      end
      ST_FIN: begin
        if (out_free) begin
          out_data_q <= OUT_BUS_W'({phase_q[PHASE_BITS-1 -: 16],
                                    center_q ? DUTY_MID : duty_new,
                                    duty_b_q, duty_a_q});
        end
      end
      default: ;
    endcase
  end

  // a stop word drops the tick history
  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !s_axis_tuser |=> !tick_valid_q && state_q == ST_FIN)
    else $error("stop word did not clear tick history");

  // depth never exceeds the cap while duties are formed
  a_depth_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MS |-> m_q <= M_CAP)
    else $error("modulation depth above cap");

  // a result appears only from the final state
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result raised outside final state");

  // three duty passes before the final state
  a_three_phases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DM && state_d == ST_FIN |-> ch_q == 2'd3 && !center_q)
    else $error("duty sequence ended early");

  // the phase only moves on a run word
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_Q_EST |=> $stable(phase_q))
    else $error("phase moved outside its update step");

endmodule
